// File: rtl/bsc_pkg.sv
// Shared types, constants and helpers of the barometric compensation block.
`default_nettype none
package bsc_pkg;

  localparam logic [19:0] SkipCode = 20'h80000;
  localparam logic signed [63:0] SatMax = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam int QueueDepth = 2;
  localparam int PressHigh = 28160000;

  localparam logic [1:0] StatOk = 2'd0;
  localparam logic [1:0] StatSkip = 2'd1;
  localparam logic [1:0] StatDivZero = 2'd2;

  typedef enum logic [1:0] {
    RegTempCalib,
    RegPressA,
    RegPressB,
    RegPressC
  } reg_idx_e;

  typedef enum logic [4:0] {
    StIdle, StT0, StT1, StT2, StT3, StT4,
    StM1, StM2, StM3, StM4, StM5, StM6, StM7,
    StM8, StM9, StM10, StM11, StM12, StM13, StM14,
    StDiv, StF1, StF2, StF3
  } step_e;

  typedef struct packed {
    logic [19:0] temp_raw;
    logic [19:0] press_raw;
    logic        skip;
  } req_t;

  typedef struct packed {
    logic               start;
    logic signed [63:0] a;
    logic signed [63:0] b;
  } op_req_t;

  function automatic logic [63:0] mag64(input logic signed [63:0] x);
    logic [63:0] r;
    r = x[63] ? 64'(-x) : 64'(x);
    return r;
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    logic signed [64:0] hi;
    s = {a[63], a} + {b[63], b};
    hi = {1'b0, SatMax};
    if (s > hi) begin
      return SatMax;
    end else if (s < -hi) begin
      return -SatMax;
    end
    return s[63:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/barometric_sensor_compensation.sv
// Top level of the barometric pressure and temperature compensation block.
//
//   channel   signals                                     direction
//   config    cfg_we_i, cfg_idx_i, cfg_data_i             in
//   request   start, busy, temp_raw_i, press_raw_i        in / busy out
//   result    done_o, temp_centi_c_o, temp_centi_f_o,     out
//             pressure_q8_o, status_o
//
// A request takes fourteen passes through the shared multiplier and one pass through
// the divider. A skipped measurement returns from the idle state without using either
// unit; a zero divisor ends after the ninth multiplier pass.
// Two requests queue ahead of the sequencer; busy is high while the queue is full.
// Reset clears the queue, sequencer and calibration words. The receiver cannot stall.
`default_nettype none
module barometric_sensor_compensation (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [47:0]        cfg_data_i,
  input  wire logic               start,
  input  wire logic [19:0]        temp_raw_i,
  input  wire logic [19:0]        press_raw_i,
  output logic                    busy,
  output logic                    done_o,
  output logic signed [14:0]      temp_centi_c_o,
  output logic signed [15:0]      temp_centi_f_o,
  output logic [24:0]             pressure_q8_o,
  output logic [1:0]              status_o
);

  logic [47:0]   tcal_q, pca_q, pcb_q, pcc_q;
  logic          q_valid, q_pop;
  bsc_pkg::req_t q_req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tcal_q <= '0;
      pca_q  <= '0;
      pcb_q  <= '0;
      pcc_q  <= '0;
    end else if (cfg_we_i) begin
      case (bsc_pkg::reg_idx_e'(cfg_idx_i))
        bsc_pkg::RegTempCalib: tcal_q <= cfg_data_i;
        bsc_pkg::RegPressA:    pca_q  <= cfg_data_i;
        bsc_pkg::RegPressB:    pcb_q  <= cfg_data_i;
        bsc_pkg::RegPressC:    pcc_q  <= cfg_data_i;
        default:               tcal_q <= tcal_q;
      endcase
    end
  end

  bsc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .temp_raw_i  (temp_raw_i),
    .press_raw_i (press_raw_i),
    .busy_o      (busy),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .req_o       (q_req)
  );

  bsc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (q_valid),
    .req_i           (q_req),
    .pop_o           (q_pop),
    .temp_calib_i    (tcal_q),
    .press_calib_a_i (pca_q),
    .press_calib_b_i (pcb_q),
    .press_calib_c_i (pcc_q),
    .done_o          (done_o),
    .temp_centi_c_o  (temp_centi_c_o),
    .temp_centi_f_o  (temp_centi_f_o),
    .pressure_q8_o   (pressure_q8_o),
    .status_o        (status_o)
  );

endmodule
`default_nettype wire

// File: rtl/bsc_mul.sv
// Sequential saturating 64x64 signed multiplier built from 32x32 partial products.
`default_nettype none
module bsc_mul (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire bsc_pkg::op_req_t   req_i,
  output logic                    done_o,
  output logic signed [63:0]      res_o
);

  logic               busy_q, busy_d;
  logic [2:0]         cnt_q, cnt_d;
  logic [63:0]        ua_q, ua_d, ub_q, ub_d;
  logic               neg_q, neg_d;
  logic [63:0]        pp_q, pp_d;
  logic [1:0]         sh_q, sh_d;
  logic [127:0]       acc_q, acc_d;
  logic               done_q, done_d;
  logic signed [63:0] res_q, res_d;

  always_comb begin
    logic [31:0]  ah;
    logic [31:0]  bh;
    logic [127:0] pp_sh;
    logic [127:0] sum;
    logic [63:0]  m;
    busy_d = busy_q;
    cnt_d  = cnt_q;
    ua_d   = ua_q;
    ub_d   = ub_q;
    neg_d  = neg_q;
    pp_d   = pp_q;
    sh_d   = sh_q;
    acc_d  = acc_q;
    done_d = 1'b0;
    res_d  = res_q;
    ah = cnt_q[1] ? ua_q[63:32] : ua_q[31:0];
    bh = cnt_q[0] ? ub_q[63:32] : ub_q[31:0];
    case (sh_q)
      2'd0:    pp_sh = {64'b0, pp_q};
      2'd1:    pp_sh = {32'b0, pp_q, 32'b0};
      default: pp_sh = {pp_q, 64'b0};
    endcase
    sum = acc_q + pp_sh;
    m = |sum[127:63] ? 64'(bsc_pkg::SatMax) : sum[63:0];
    if (req_i.start) begin
      ua_d   = bsc_pkg::mag64(req_i.a);
      ub_d   = bsc_pkg::mag64(req_i.b);
      neg_d  = req_i.a[63] ^ req_i.b[63];
      busy_d = 1'b1;
      cnt_d  = 3'd0;
      acc_d  = '0;
    end else if (busy_q) begin
      if (cnt_q != 3'd4) begin
        pp_d = 64'(ah) * 64'(bh);
        sh_d = {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
      end
      if (cnt_q != 3'd0) begin
        acc_d = sum;
      end
      if (cnt_q == 3'd4) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        res_d  = neg_q ? -$signed(m) : $signed(m);
      end
      cnt_d = cnt_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ua_q  <= ua_d;
    ub_q  <= ub_d;
    neg_q <= neg_d;
    pp_q  <= pp_d;
    sh_q  <= sh_d;
    acc_q <= acc_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
`default_nettype wire

// File: rtl/bsc_div.sv
// Radix-2 restoring signed divider, quotient truncated toward zero.
`default_nettype none
module bsc_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire bsc_pkg::op_req_t   req_i,
  output logic                    done_o,
  output logic signed [63:0]      res_o
);

  logic               busy_q, busy_d;
  logic [5:0]         cnt_q, cnt_d;
  logic [63:0]        rem_q, rem_d;
  logic [63:0]        quo_q, quo_d;
  logic [63:0]        den_q, den_d;
  logic               neg_q, neg_d;
  logic               done_q, done_d;
  logic signed [63:0] res_q, res_d;

  always_comb begin
    logic [64:0] trial;
    logic [64:0] diff;
    logic        bit_q;
    logic [63:0] nq;
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    neg_d  = neg_q;
    done_d = 1'b0;
    res_d  = res_q;
    trial = {rem_q, quo_q[63]};
    diff  = trial - {1'b0, den_q};
    bit_q = !diff[64];
    nq    = {quo_q[62:0], bit_q};
    if (req_i.start) begin
      quo_d  = bsc_pkg::mag64(req_i.a);
      den_d  = bsc_pkg::mag64(req_i.b);
      neg_d  = req_i.a[63] ^ req_i.b[63];
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = bit_q ? diff[63:0] : trial[63:0];
      quo_d = nq;
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        res_d  = neg_q ? -$signed(nq) : $signed(nq);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
`default_nettype wire

// File: rtl/bsc_front.sv
// Request intake: skip detection and a short queue toward the compute sequencer.
`default_nettype none
module bsc_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [19:0]   temp_raw_i,
  input  wire logic [19:0]   press_raw_i,
  output logic               busy_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output bsc_pkg::req_t      req_o
);

  localparam int PtrW = (bsc_pkg::QueueDepth > 1) ? $clog2(bsc_pkg::QueueDepth) : 1;
  localparam int CntW = $clog2(bsc_pkg::QueueDepth + 1);

  bsc_pkg::req_t       mem_q [bsc_pkg::QueueDepth];
  logic [PtrW-1:0]     wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                push, pop;
  bsc_pkg::req_t       entry;

  assign busy_o  = (cnt_q == CntW'(bsc_pkg::QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign push    = start_i && !busy_o;
  assign pop     = pop_i && valid_o;
  assign req_o   = mem_q[rptr_q];

  always_comb begin
    entry.temp_raw  = temp_raw_i;
    entry.press_raw = press_raw_i;
    entry.skip      = (temp_raw_i == bsc_pkg::SkipCode) || (press_raw_i == bsc_pkg::SkipCode);
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == PtrW'(bsc_pkg::QueueDepth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (pop) begin
      rptr_d = (rptr_q == PtrW'(bsc_pkg::QueueDepth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= entry;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(bsc_pkg::QueueDepth)) else $error("queue count overflow");
  a_cnt_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + CntW'(1))) else $error("queue count slip");
`endif

endmodule
`default_nettype wire

// File: rtl/bsc_back.sv
// Compute sequencer: temperature path, pressure program on shared multiplier and divider.
`default_nettype none
module bsc_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  input  wire bsc_pkg::req_t        req_i,
  output logic                      pop_o,
  input  wire logic [47:0]          temp_calib_i,
  input  wire logic [47:0]          press_calib_a_i,
  input  wire logic [47:0]          press_calib_b_i,
  input  wire logic [47:0]          press_calib_c_i,
  output logic                      done_o,
  output logic signed [14:0]        temp_centi_c_o,
  output logic signed [15:0]        temp_centi_f_o,
  output logic [24:0]               pressure_q8_o,
  output logic [1:0]                status_o
);

  bsc_pkg::step_e     st_q, st_d;
  logic               pend_q, pend_d;
  logic [19:0]        pr_q, pr_d;
  logic [19:0]        tr_q, tr_d;
  logic signed [22:0] a_q, a_d;
  logic signed [16:0] d_q, d_d;
  logic [20:0]        dd_q, dd_d;
  logic signed [24:0] fine_q, fine_d;
  logic signed [14:0] tc_q, tc_d;
  logic signed [15:0] tf_q, tf_d;
  logic signed [63:0] v_q, v_d, vv_q, vv_d, w_q, w_d, x_q, x_d, t_q, t_d;
  logic signed [63:0] p_q, p_d, pa_q, pa_d, pb_q, pb_d;
  logic               done_q, done_d;
  logic signed [14:0] oc_q, oc_d;
  logic signed [15:0] of_q, of_d;
  logic [24:0]        op_q, op_d;
  logic [1:0]         os_q, os_d;

  bsc_pkg::op_req_t   mreq, dreq;
  logic               mdone, ddone;
  logic signed [63:0] mres, dres;

  bsc_mul u_mul (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(mreq), .done_o(mdone), .res_o(mres));
  bsc_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(dreq), .done_o(ddone), .res_o(dres));

  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3;
  logic signed [63:0] p2, p3, p4, p5, p6, p7, p8, p9;

  assign t1 = temp_calib_i[15:0];
  assign t2 = $signed(temp_calib_i[31:16]);
  assign t3 = $signed(temp_calib_i[47:32]);
  assign p1 = press_calib_a_i[15:0];
  assign p2 = {{48{press_calib_a_i[31]}}, press_calib_a_i[31:16]};
  assign p3 = {{48{press_calib_a_i[47]}}, press_calib_a_i[47:32]};
  assign p4 = {{48{press_calib_b_i[15]}}, press_calib_b_i[15:0]};
  assign p5 = {{48{press_calib_b_i[31]}}, press_calib_b_i[31:16]};
  assign p6 = {{48{press_calib_b_i[47]}}, press_calib_b_i[47:32]};
  assign p7 = {{48{press_calib_c_i[15]}}, press_calib_c_i[15:0]};
  assign p8 = {{48{press_calib_c_i[31]}}, press_calib_c_i[31:16]};
  assign p9 = {{48{press_calib_c_i[47]}}, press_calib_c_i[47:32]};

  assign pop_o = (st_q == bsc_pkg::StIdle) && valid_i;

  always_comb begin
    logic signed [17:0] diff;
    logic signed [33:0] prod_a;
    logic signed [33:0] prod_d;
    logic signed [37:0] prod_b;
    logic signed [23:0] b_t;
    logic signed [27:0] tcx;
    logic signed [27:0] tcs;
    logic signed [17:0] n9;
    logic [16:0]        m9;
    logic [34:0]        q35;
    logic [15:0]        q16;
    logic signed [63:0] ma, mb;
    logic               is_mul;
    logic signed [63:0] s;
    st_d   = st_q;
    pend_d = pend_q;
    tr_d   = tr_q;
    pr_d   = pr_q;
    a_d    = a_q;
    d_d    = d_q;
    dd_d   = dd_q;
    fine_d = fine_q;
    tc_d   = tc_q;
    tf_d   = tf_q;
    v_d    = v_q;
    vv_d   = vv_q;
    w_d    = w_q;
    x_d    = x_q;
    t_d    = t_q;
    p_d    = p_q;
    pa_d   = pa_q;
    pb_d   = pb_q;
    done_d = 1'b0;
    oc_d   = oc_q;
    of_d   = of_q;
    op_d   = op_q;
    os_d   = os_q;
    dreq.start = 1'b0;
    dreq.a     = t_q;
    dreq.b     = x_q;
    diff   = $signed({1'b0, tr_q[19:3]}) - $signed({1'b0, t1, 1'b0});
    prod_a = diff * t2;
    prod_d = d_q * d_q;
    prod_b = $signed({1'b0, dd_q}) * t3;
    b_t    = 24'(prod_b >>> 14);
    tcx    = {{3{fine_q[24]}}, fine_q} * 28'sd5 + 28'sd128;
    tcs    = tcx >>> 8;
    n9     = {{3{tc_q[14]}}, tc_q} * 18'sd9;
    m9     = n9[17] ? 17'(-n9) : 17'(n9);
    q35    = 35'(m9) * 35'd209716;
    q16    = {1'b0, q35[34:20]};
    s      = bsc_pkg::sat_add(pa_q, p7 <<< 4);
    is_mul = 1'b1;
    ma     = v_q;
    mb     = v_q;
    case (st_q)
      bsc_pkg::StM1:  begin ma = v_q;  mb = v_q; end
      bsc_pkg::StM2:  begin ma = vv_q; mb = p6; end
      bsc_pkg::StM3:  begin ma = v_q;  mb = p5; end
      bsc_pkg::StM4:  begin ma = t_q;  mb = 64'sh2_0000; end
      bsc_pkg::StM5:  begin ma = p4;   mb = 64'sh8_0000_0000; end
      bsc_pkg::StM6:  begin ma = vv_q; mb = p3; end
      bsc_pkg::StM7:  begin ma = v_q;  mb = p2; end
      bsc_pkg::StM8:  begin ma = t_q;  mb = 64'sh1000; end
      bsc_pkg::StM9:  begin
        ma = bsc_pkg::sat_add(64'sh8000_0000_0000, x_q);
        mb = {48'b0, p1};
      end
      bsc_pkg::StM10: begin ma = 64'sd1048576 - {44'b0, pr_q}; mb = 64'sh8000_0000; end
      bsc_pkg::StM11: begin ma = bsc_pkg::sat_add(t_q, -w_q); mb = 64'sd3125; end
      bsc_pkg::StM12: begin ma = p9;   mb = p_q >>> 13; end
      bsc_pkg::StM13: begin ma = t_q;  mb = p_q >>> 13; end
      bsc_pkg::StM14: begin ma = p8;   mb = p_q; end
      default:        is_mul = 1'b0;
    endcase
    mreq.start = is_mul && !pend_q;
    mreq.a     = ma;
    mreq.b     = mb;
    if (mreq.start) begin
      pend_d = 1'b1;
    end
    case (st_q)
      bsc_pkg::StIdle: begin
        if (valid_i) begin
          tr_d = req_i.temp_raw;
          pr_d = req_i.press_raw;
          if (req_i.skip) begin
            done_d = 1'b1;
            oc_d   = '0;
            of_d   = '0;
            op_d   = '0;
            os_d   = bsc_pkg::StatSkip;
          end else begin
            st_d = bsc_pkg::StT0;
          end
        end
      end
      bsc_pkg::StT0: begin
        a_d  = 23'(prod_a >>> 11);
        d_d  = $signed({1'b0, tr_q[19:4]}) - $signed({1'b0, t1});
        st_d = bsc_pkg::StT1;
      end
      bsc_pkg::StT1: begin
        dd_d = prod_d[32:12];
        st_d = bsc_pkg::StT2;
      end
      bsc_pkg::StT2: begin
        fine_d = {{2{a_q[22]}}, a_q} + {b_t[23], b_t};
        st_d   = bsc_pkg::StT3;
      end
      bsc_pkg::StT3: begin
        if (tcs < -28'sd4000) begin
          tc_d = -15'sd4000;
        end else if (tcs > 28'sd8500) begin
          tc_d = 15'sd8500;
        end else begin
          tc_d = tcs[14:0];
        end
        st_d = bsc_pkg::StT4;
      end
      bsc_pkg::StT4: begin
        tf_d = (n9[17] ? -$signed(q16) : $signed(q16)) + 16'sd3200;
        v_d  = {{39{fine_q[24]}}, fine_q} - 64'sd128000;
        st_d = bsc_pkg::StM1;
      end
      bsc_pkg::StDiv: begin
        if (!pend_q) begin
          dreq.start = 1'b1;
          pend_d     = 1'b1;
        end else if (ddone) begin
          p_d    = dres;
          pend_d = 1'b0;
          st_d   = bsc_pkg::StM12;
        end
      end
      bsc_pkg::StF1: begin
        pa_d = bsc_pkg::sat_add(p_q, pa_q);
        st_d = bsc_pkg::StF2;
      end
      bsc_pkg::StF2: begin
        pa_d = bsc_pkg::sat_add(pa_q, pb_q) >>> 8;
        st_d = bsc_pkg::StF3;
      end
      bsc_pkg::StF3: begin
        done_d = 1'b1;
        oc_d   = tc_q;
        of_d   = tf_q;
        os_d   = bsc_pkg::StatOk;
        if (s < 64'sd0) begin
          op_d = '0;
        end else if (s > 64'(bsc_pkg::PressHigh)) begin
          op_d = 25'(bsc_pkg::PressHigh);
        end else begin
          op_d = s[24:0];
        end
        st_d = bsc_pkg::StIdle;
      end
      default: begin
        if (pend_q && mdone) begin
          pend_d = 1'b0;
          case (st_q)
            bsc_pkg::StM1:  begin vv_d = mres; st_d = bsc_pkg::StM2; end
            bsc_pkg::StM2:  begin w_d = mres; st_d = bsc_pkg::StM3; end
            bsc_pkg::StM3:  begin t_d = mres; st_d = bsc_pkg::StM4; end
            bsc_pkg::StM4:  begin w_d = bsc_pkg::sat_add(w_q, mres); st_d = bsc_pkg::StM5; end
            bsc_pkg::StM5:  begin w_d = bsc_pkg::sat_add(w_q, mres); st_d = bsc_pkg::StM6; end
            bsc_pkg::StM6:  begin x_d = mres >>> 8; st_d = bsc_pkg::StM7; end
            bsc_pkg::StM7:  begin t_d = mres; st_d = bsc_pkg::StM8; end
            bsc_pkg::StM8:  begin x_d = bsc_pkg::sat_add(x_q, mres); st_d = bsc_pkg::StM9; end
            bsc_pkg::StM9:  begin
              x_d = mres >>> 33;
              if ((mres >>> 33) == 64'sd0) begin
                done_d = 1'b1;
                oc_d   = tc_q;
                of_d   = tf_q;
                op_d   = '0;
                os_d   = bsc_pkg::StatDivZero;
                st_d   = bsc_pkg::StIdle;
              end else begin
                st_d = bsc_pkg::StM10;
              end
            end
            bsc_pkg::StM10: begin t_d = mres; st_d = bsc_pkg::StM11; end
            bsc_pkg::StM11: begin t_d = mres; st_d = bsc_pkg::StDiv; end
            bsc_pkg::StM12: begin t_d = mres; st_d = bsc_pkg::StM13; end
            bsc_pkg::StM13: begin pa_d = mres >>> 25; st_d = bsc_pkg::StM14; end
            bsc_pkg::StM14: begin pb_d = mres >>> 19; st_d = bsc_pkg::StF1; end
            default:        st_d = bsc_pkg::StIdle;
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= bsc_pkg::StIdle;
      pend_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      pend_q <= pend_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tr_q   <= tr_d;
    pr_q   <= pr_d;
    a_q    <= a_d;
    d_q    <= d_d;
    dd_q   <= dd_d;
    fine_q <= fine_d;
    tc_q   <= tc_d;
    tf_q   <= tf_d;
    v_q    <= v_d;
    vv_q   <= vv_d;
    w_q    <= w_d;
    x_q    <= x_d;
    t_q    <= t_d;
    p_q    <= p_d;
    pa_q   <= pa_d;
    pb_q   <= pb_d;
    oc_q   <= oc_d;
    of_q   <= of_d;
    op_q   <= op_d;
    os_q   <= os_d;
  end

  assign done_o         = done_q;
  assign temp_centi_c_o = oc_q;
  assign temp_centi_f_o = of_q;
  assign pressure_q8_o  = op_q;
  assign status_o       = os_q;

`ifndef SYNTHESIS
  a_done_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (os_q <= bsc_pkg::StatDivZero)) else $error("result status out of range");
  a_pend_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (st_q != bsc_pkg::StIdle)) else $error("unit pending while idle");
`endif

endmodule
`default_nettype wire

// File: tb/tb_barometric_sensor_compensation.sv
// Testbench for barometric_sensor_compensation: random and directed requests checked by a scoreboard.
`default_nettype none
module tb_barometric_sensor_compensation;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [14:0] centi_c;
    logic signed [15:0] centi_f;
    logic [24:0]        press_q8;
    logic [1:0]         stat;
  } reading_t;

  class compensation_scoreboard;
    logic [47:0] calib[4];
    reading_t    pending[$];
    int          errors;

    function new();
      foreach (calib[i]) calib[i] = '0;
      errors = 0;
    endfunction

    function void set_reg(bsc_pkg::reg_idx_e idx, logic [47:0] data);
      calib[idx] = data;
    endfunction

    static function longint clamp_mul(longint a, longint b);
      logic signed [127:0] prod;
      prod = 128'(a) * 128'(b);
      if (prod > 128'(bsc_pkg::SatMax)) return bsc_pkg::SatMax;
      if (prod < -128'(bsc_pkg::SatMax)) return -bsc_pkg::SatMax;
      return longint'(prod);
    endfunction

    static function longint clamp_add(longint a, longint b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s > 65'(bsc_pkg::SatMax)) return bsc_pkg::SatMax;
      if (s < -65'(bsc_pkg::SatMax)) return -bsc_pkg::SatMax;
      return longint'(s);
    endfunction

    function reading_t compensate(logic [19:0] tr, logic [19:0] pr);
      reading_t r;
      longint t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      longint at, d, a, b, fine, tc, tf, v, w, x, p;
      r = '{default: '0};
      if (tr == bsc_pkg::SkipCode || pr == bsc_pkg::SkipCode) begin
        r.stat = bsc_pkg::StatSkip;
        return r;
      end
      t1 = longint'(calib[bsc_pkg::RegTempCalib][15:0]);
      t2 = longint'($signed(calib[bsc_pkg::RegTempCalib][31:16]));
      t3 = longint'($signed(calib[bsc_pkg::RegTempCalib][47:32]));
      p1 = longint'(calib[bsc_pkg::RegPressA][15:0]);
      p2 = longint'($signed(calib[bsc_pkg::RegPressA][31:16]));
      p3 = longint'($signed(calib[bsc_pkg::RegPressA][47:32]));
      p4 = longint'($signed(calib[bsc_pkg::RegPressB][15:0]));
      p5 = longint'($signed(calib[bsc_pkg::RegPressB][31:16]));
      p6 = longint'($signed(calib[bsc_pkg::RegPressB][47:32]));
      p7 = longint'($signed(calib[bsc_pkg::RegPressC][15:0]));
      p8 = longint'($signed(calib[bsc_pkg::RegPressC][31:16]));
      p9 = longint'($signed(calib[bsc_pkg::RegPressC][47:32]));
      at = longint'(tr);
      a = (((at >>> 3) - t1 * 2) * t2) >>> 11;
      d = (at >>> 4) - t1;
      b = (((d * d) >>> 12) * t3) >>> 14;
      fine = a + b;
      tc = (fine * 5 + 128) >>> 8;
      if (tc < -4000) tc = -4000;
      if (tc > 8500) tc = 8500;
      tf = tc * 9 / 5 + 3200;
      r.centi_c = tc[14:0];
      r.centi_f = tf[15:0];
      v = fine - 128000;
      w = clamp_mul(clamp_mul(v, v), p6);
      w = clamp_add(w, clamp_mul(clamp_mul(v, p5), 64'sd1 <<< 17));
      w = clamp_add(w, clamp_mul(p4, 64'sd1 <<< 35));
      x = clamp_add(clamp_mul(clamp_mul(v, v), p3) >>> 8,
                    clamp_mul(clamp_mul(v, p2), 64'sd1 <<< 12));
      x = clamp_mul(clamp_add(64'sd1 <<< 47, x), p1) >>> 33;
      if (x == 0) begin
        r.stat = bsc_pkg::StatDivZero;
        return r;
      end
      p = 1048576 - longint'(pr);
      p = clamp_mul(clamp_add(clamp_mul(p, 64'sd1 <<< 31), -w), 3125) / x;
      a = clamp_mul(clamp_mul(p9, p >>> 13), p >>> 13) >>> 25;
      b = clamp_mul(p8, p) >>> 19;
      p = clamp_add(clamp_add(clamp_add(p, a), b) >>> 8, p7 * 16);
      if (p < 0) p = 0;
      if (p > bsc_pkg::PressHigh) p = bsc_pkg::PressHigh;
      r.press_q8 = p[24:0];
      r.stat = bsc_pkg::StatOk;
      return r;
    endfunction

    function void note_request(logic [19:0] tr, logic [19:0] pr);
      pending.push_back(compensate(tr, pr));
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check(logic signed [14:0] c, logic signed [15:0] f,
               logic [24:0] q, logic [1:0] s);
      reading_t e;
      if (pending.size() == 0) begin
        report("result with no request pending");
        return;
      end
      e = pending.pop_front();
      if (c !== e.centi_c) report($sformatf("temp_centi_c %0d exp %0d", c, e.centi_c));
      if (f !== e.centi_f) report($sformatf("temp_centi_f %0d exp %0d", f, e.centi_f));
      if (q !== e.press_q8) report($sformatf("pressure_q8 %0d exp %0d", q, e.press_q8));
      if (s !== e.stat) report($sformatf("status %0d exp %0d", s, e.stat));
    endtask
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [1:0]         cfg_idx_i;
  logic [47:0]        cfg_data_i;
  logic               start;
  logic [19:0]        temp_raw_i;
  logic [19:0]        press_raw_i;
  logic               busy;
  logic               done_o;
  logic signed [14:0] temp_centi_c_o;
  logic signed [15:0] temp_centi_f_o;
  logic [24:0]        pressure_q8_o;
  logic [1:0]         status_o;

  compensation_scoreboard sb = new();
  int  stall_cycles;
  bit  calm;

  barometric_sensor_compensation uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .start,
    .temp_raw_i, .press_raw_i, .busy, .done_o, .temp_centi_c_o,
    .temp_centi_f_o, .pressure_q8_o, .status_o
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      sb.check(temp_centi_c_o, temp_centi_f_o, pressure_q8_o, status_o);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || done_o || (start && !busy)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= 20000) begin
      $display("tb_barometric_sensor_compensation: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic write_calib(logic [47:0] tc, logic [47:0] pa, logic [47:0] pb,
                             logic [47:0] pc);
    logic [47:0] vals[4];
    vals = '{tc, pa, pb, pc};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= bsc_pkg::reg_idx_e'(i);
      cfg_data_i <= vals[i];
      sb.set_reg(bsc_pkg::reg_idx_e'(i), vals[i]);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send(logic [19:0] tr, logic [19:0] pr);
    start       <= 1'b1;
    temp_raw_i  <= tr;
    press_raw_i <= pr;
    do @(posedge clk_i); while (busy);
    sb.note_request(tr, pr);
    if (!calm && $urandom_range(99) < 22) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic send_random();
    int sel;
    sel = $urandom_range(99);
    if (sel < 70) begin
      send(20'($urandom_range(440000, 600000)), 20'($urandom_range(250000, 550000)));
    end else if (sel < 90) begin
      send(20'($urandom), 20'($urandom));
    end else begin
      case ($urandom_range(4))
        0: send(bsc_pkg::SkipCode, 20'($urandom));
        1: send(20'($urandom), bsc_pkg::SkipCode);
        2: send(20'h00000, 20'($urandom));
        3: send(20'hFFFFF, 20'($urandom));
        default: send(20'($urandom), $urandom_range(1) ? 20'h00000 : 20'hFFFFF);
      endcase
    end
  endtask

  localparam logic [47:0] TypT = {16'hFC18, 16'd26435, 16'd27504};
  localparam logic [47:0] TypA = {16'd3024, 16'hD643, 16'd36477};
  localparam logic [47:0] TypB = {16'hFFF9, 16'd140, 16'd2855};
  localparam logic [47:0] TypC = {16'd6000, 16'hC6F8, 16'd15500};

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    start = 1'b0;
    temp_raw_i = '0;
    press_raw_i = '0;
    calm = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(20'd519888, 20'd415148);
    drain();
    write_calib(TypT, TypA, TypB, TypC);
    send(20'd519888, 20'd415148);
    send(20'h00000, 20'h00000);
    send(20'hFFFFF, 20'hFFFFF);
    send(20'h00000, 20'hFFFFF);
    send(20'hFFFFF, 20'h00000);
    send(bsc_pkg::SkipCode, 20'd415148);
    send(20'd519888, bsc_pkg::SkipCode);
    send(bsc_pkg::SkipCode, bsc_pkg::SkipCode);
    send(20'd300000, 20'd415148);
    send(20'd800000, 20'd415148);
    send(20'h7FFFF, 20'h80001);
    send(20'd519888, 20'd1);
    drain();
    write_calib(TypT, {TypA[47:16], 16'd0}, TypB, TypC);
    send(20'd519888, 20'd415148);
    send(bsc_pkg::SkipCode, 20'd1);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: write_calib(TypT, TypA, TypB, TypC);
        1: write_calib('0, '0, '0, '0);
        2: write_calib('1, '1, '1, '1);
        3: write_calib({3{16'h7FFF}} | 48'hFFFF, {3{16'h7FFF}} | 48'hFFFF,
                       {3{16'h7FFF}}, {3{16'h7FFF}});
        4: write_calib({3{16'h8000}} & ~48'hFFFF, {3{16'h8000}} & ~48'hFFFF,
                       {3{16'h8000}}, {3{16'h8000}});
        5: write_calib(TypT ^ 48'($urandom_range(255)), TypA ^ 48'($urandom_range(255)),
                       TypB ^ 48'($urandom_range(255)), TypC ^ 48'($urandom_range(255)));
        default: write_calib({$urandom, $urandom}, {$urandom, $urandom},
                             {$urandom, $urandom}, {$urandom, $urandom});
      endcase
      for (int i = 0; i < 160; i++) begin
        calm = (ph == 0 && i >= 40 && i < 120);
        send_random();
      end
      calm = 1'b0;
      drain();
    end

    for (int i = 0; i < 3; i++) begin
      write_calib({$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom});
      repeat (5) send_random();
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_barometric_sensor_compensation: PASS");
    end else begin
      $display("tb_barometric_sensor_compensation: FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
